// File: hdl/bip_pkg.sv
package bip_pkg;

    // Operator codes as held on the stack; the order gives the precedence.
    localparam logic [2:0] OP_LPAR = 3'd0;
    localparam logic [2:0] OP_IFF  = 3'd1;
    localparam logic [2:0] OP_IMP  = 3'd2;
    localparam logic [2:0] OP_OR   = 3'd3;
    localparam logic [2:0] OP_XOR  = 3'd4;
    localparam logic [2:0] OP_AND  = 3'd5;
    localparam logic [2:0] OP_NOT  = 3'd6;

    // Status codes reported at the end of an expression.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BADCHAR   = 3'd1;
    localparam logic [2:0] ST_MISPLACED = 3'd2;
    localparam logic [2:0] ST_PARENS    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_TOOLONG   = 3'd5;

    // Item kinds on both channels.
    localparam logic FN_CHAR  = 1'b0;
    localparam logic FN_END   = 1'b1;
    localparam logic KD_TOKEN = 1'b0;
    localparam logic KD_STAT  = 1'b1;

    // Characters of the expression language.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_IFF   = 8'h3D;
    localparam logic [7:0] CH_IMP   = 8'h3E;
    localparam logic [7:0] CH_OR    = 8'h7C;
    localparam logic [7:0] CH_XOR   = 8'h23;
    localparam logic [7:0] CH_AND   = 8'h26;
    localparam logic [7:0] CH_NOT   = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;

    // One stack entry: operator code and its source position.
    typedef struct packed {
        logic [2:0] code;
        logic [7:0] pos;
    } t_entry;

    // Shift command broadcast to every stack cell.
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_cmd;

    // Character classes.
    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_OPND,
        CLS_LPAR,
        CLS_RPAR,
        CLS_NOT,
        CLS_BIN,
        CLS_BAD
    } t_cls;

    function automatic t_cls char_class(input logic [7:0] c);
        t_cls cls;
        unique case (c) inside
            CH_SPACE:                           cls = CLS_SPACE;
            [CH_LOW_A:CH_LOW_Z], CH_ZERO, CH_ONE: cls = CLS_OPND;
            CH_LPAR:                            cls = CLS_LPAR;
            CH_RPAR:                            cls = CLS_RPAR;
            CH_NOT:                             cls = CLS_NOT;
            CH_IFF, CH_IMP, CH_OR, CH_XOR, CH_AND: cls = CLS_BIN;
            default:                            cls = CLS_BAD;
        endcase
        return cls;
    endfunction

    function automatic logic [2:0] op_code(input logic [7:0] c);
        logic [2:0] code;
        unique case (c)
            CH_IFF:  code = OP_IFF;
            CH_IMP:  code = OP_IMP;
            CH_OR:   code = OP_OR;
            CH_XOR:  code = OP_XOR;
            CH_AND:  code = OP_AND;
            CH_NOT:  code = OP_NOT;
            default: code = OP_LPAR;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] code_char(input logic [2:0] code);
        logic [7:0] c;
        unique case (code)
            OP_LPAR: c = CH_LPAR;
            OP_IFF:  c = CH_IFF;
            OP_IMP:  c = CH_IMP;
            OP_OR:   c = CH_OR;
            OP_XOR:  c = CH_XOR;
            OP_AND:  c = CH_AND;
            OP_NOT:  c = CH_NOT;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/bip_stack_cell.sv
module bip_stack_cell (
    input  logic              i_clk,
    input  bip_pkg::t_stk_cmd i_cmd,
    input  bip_pkg::t_entry   i_from_above,
    input  bip_pkg::t_entry   i_from_below,
    output bip_pkg::t_entry   o_entry
);

    bip_pkg::t_entry r_entry;

    // A push moves every entry one cell down, a pop one cell up.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_entry <= i_from_above;
        end else if (i_cmd.pop) begin
            r_entry <= i_from_below;
        end
    end

    assign o_entry = r_entry;

endmodule

// File: hdl/boolean_infix_to_postfix_unit.sv
// Boolean infix to postfix converter.
// Input channel (i_in_valid / o_in_ready) carries one transaction per
// expression character (i_func = 0) and a final end transaction (i_func = 1).
// Output channel (o_out_valid / i_out_ready) carries postfix tokens with their
// source positions, and after the end transaction one status transaction
// (o_kind = 1). o_last marks the final output caused by one input transaction.
// An input transaction is accepted, then decoded; operators that must leave the
// stack are then popped one at a time, followed by the closing push or
// parenthesis removal. A clean end transaction is accepted, decoded, pops
// each stack entry, sees the stack empty and then sends the status; a failed
// one skips the drain.
// The stack is a row of cells that all shift one place per push or pop, so one
// operator is popped per cycle while the output register is free.
// After the first syntax error no tokens are sent; the status reports it.
// Reset (synchronous, active low) empties the stack and clears the output.
// A stalled receiver holds the output register; the block waits on any pop,
// operand or status that needs to send, and still accepts a new input transaction while
// the last result of the previous one waits.
module boolean_infix_to_postfix_unit #(
    parameter int STACK_DEPTH = 32,
    parameter int MAX_LEN     = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_func,
    input  logic [7:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_kind,
    output logic [7:0] o_token_char,
    output logic [7:0] o_source_position,
    output logic [2:0] o_status,
    output logic       o_last
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAR,
        S_POP_OP,
        S_POP_RP,
        S_POP_END,
        S_STATUS
    } t_state;

    t_state             r_state, n_state;
    logic               r_func, n_func;
    logic [7:0]         r_char, n_char;
    logic [2:0]         r_tcode, n_tcode;
    logic [7:0]         r_tpos, n_tpos;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_paren, n_paren;
    logic               r_want, n_want;
    logic [IDX_W-1:0]   r_char_idx, n_char_idx;
    logic [2:0]         r_err, n_err;
    logic               r_out_valid, n_out_valid;
    logic               r_kind, n_kind;
    logic [7:0]         r_tok, n_tok;
    logic [7:0]         r_spos, n_spos;
    logic [2:0]         r_status, n_status;
    logic               r_last, n_last;

    bip_pkg::t_stk_cmd  w_cmd;
    bip_pkg::t_entry    w_push_data;
    bip_pkg::t_entry    w_cell [STACK_DEPTH];
    bip_pkg::t_entry    w_top;
    bip_pkg::t_entry    w_next;
    bip_pkg::t_cls      w_cls;
    logic [7:0]         w_pos;
    logic               w_out_free;
    logic               w_full;
    logic               w_has_next;
    logic               w_op_cont;
    logic               w_op_cont_next;
    logic               w_right;

    // Stack: a row of shift cells, entry 0 is the top.
    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        bip_pkg::t_entry w_above;
        bip_pkg::t_entry w_below;
        if (gi == 0) begin : g_first
            assign w_above = w_push_data;
        end else begin : g_inner_above
            assign w_above = w_cell[gi-1];
        end
        if (gi == STACK_DEPTH - 1) begin : g_last
            assign w_below = w_cell[gi];
        end else begin : g_inner_below
            assign w_below = w_cell[gi+1];
        end
        bip_stack_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_entry      (w_cell[gi])
        );
    end

    assign w_top      = w_cell[0];
    assign w_next     = w_cell[1];
    assign w_pos      = 8'(r_char_idx);
    assign w_cls      = bip_pkg::char_class(r_char);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_full     = (r_count == CNT_W'(STACK_DEPTH));
    assign w_has_next = (r_count > CNT_W'(1));
    assign w_right    = (r_tcode == bip_pkg::OP_IMP);

    // Pop test for a binary operator against the top and the entry below it.
    assign w_op_cont = (r_count != '0) && (w_top.code != bip_pkg::OP_LPAR) &&
                       (w_right ? (r_tcode < w_top.code) : (r_tcode <= w_top.code));
    assign w_op_cont_next = w_has_next && (w_next.code != bip_pkg::OP_LPAR) &&
                       (w_right ? (r_tcode < w_next.code) : (r_tcode <= w_next.code));

    assign o_in_ready = (r_state == S_IDLE);

    // Next-state and datapath decisions.
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_char      = r_char;
        n_tcode     = r_tcode;
        n_tpos      = r_tpos;
        n_count     = r_count;
        n_paren     = r_paren;
        n_want      = r_want;
        n_char_idx  = r_char_idx;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind      = r_kind;
        n_tok       = r_tok;
        n_spos      = r_spos;
        n_status    = r_status;
        n_last      = r_last;
        w_cmd       = '0;
        w_push_data = '{code: r_tcode, pos: r_tpos};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_func;
                    n_char  = i_char_code;
                    n_state = S_CHAR;
                end
            end

            S_CHAR: begin
                n_state = S_IDLE;
                if (r_func == bip_pkg::FN_END) begin
                    // End transaction: settle the status and, if clean, drain the stack.
                    if (r_err != bip_pkg::ST_OK) begin
                        n_state = S_STATUS;
                    end else if (r_want) begin
                        n_err   = bip_pkg::ST_MISPLACED;
                        n_state = S_STATUS;
                    end else if (r_paren != '0) begin
                        n_err   = bip_pkg::ST_PARENS;
                        n_state = S_STATUS;
                    end else begin
                        n_state = S_POP_END;
                    end
                end else if (r_err != bip_pkg::ST_OK) begin
                    n_state = S_IDLE;
                end else if (r_char_idx == IDX_W'(MAX_LEN)) begin
                    n_err = bip_pkg::ST_TOOLONG;
                end else if (w_cls == bip_pkg::CLS_OPND && r_want && !w_out_free) begin
                    // Operand waits for the output register.
                    n_state = S_CHAR;
                end else begin
                    n_char_idx = r_char_idx + IDX_W'(1);
                    n_tpos     = w_pos;
                    n_tcode    = bip_pkg::op_code(r_char);
                    case (w_cls) inside
                        bip_pkg::CLS_SPACE: ;
                        bip_pkg::CLS_OPND: begin
                            if (!r_want) begin
                                n_err = bip_pkg::ST_MISPLACED;
                            end else begin
                                n_want      = 1'b0;
                                n_out_valid = 1'b1;
                                n_kind      = bip_pkg::KD_TOKEN;
                                n_tok       = r_char;
                                n_spos      = w_pos;
                                n_status    = bip_pkg::ST_OK;
                                n_last      = 1'b1;
                            end
                        end
                        bip_pkg::CLS_LPAR, bip_pkg::CLS_NOT: begin
                            if (!r_want) begin
                                n_err = bip_pkg::ST_MISPLACED;
                            end else if (w_full) begin
                                n_err = bip_pkg::ST_OVERFLOW;
                            end else begin
                                w_cmd.push  = 1'b1;
                                w_push_data = '{code: bip_pkg::op_code(r_char), pos: w_pos};
                                n_count     = r_count + CNT_W'(1);
                                if (w_cls == bip_pkg::CLS_LPAR) begin
                                    n_paren = r_paren + CNT_W'(1);
                                end
                            end
                        end
                        bip_pkg::CLS_RPAR: begin
                            if (r_paren == '0) begin
                                n_err = bip_pkg::ST_PARENS;
                            end else if (r_want) begin
                                n_err = bip_pkg::ST_MISPLACED;
                            end else begin
                                n_state = S_POP_RP;
                            end
                        end
                        bip_pkg::CLS_BIN: begin
                            if (r_want) begin
                                n_err = bip_pkg::ST_MISPLACED;
                            end else begin
                                n_state = S_POP_OP;
                            end
                        end
                        default: n_err = bip_pkg::ST_BADCHAR;
                    endcase
                end
            end

            S_POP_OP: begin
                // Pop operators of higher or equal precedence (strictly higher for implication), then push this one.
                if (w_op_cont) begin
                    if (w_out_free) begin
                        w_cmd.pop   = 1'b1;
                        n_count     = r_count - CNT_W'(1);
                        n_out_valid = 1'b1;
                        n_kind      = bip_pkg::KD_TOKEN;
                        n_tok       = bip_pkg::code_char(w_top.code);
                        n_spos      = w_top.pos;
                        n_status    = bip_pkg::ST_OK;
                        n_last      = !w_op_cont_next;
                    end
                end else begin
                    n_want  = 1'b1;
                    n_state = S_IDLE;
                    if (w_full) begin
                        n_err = bip_pkg::ST_OVERFLOW;
                    end else begin
                        w_cmd.push = 1'b1;
                        n_count    = r_count + CNT_W'(1);
                    end
                end
            end

            S_POP_RP: begin
                // Pop operators down to the matching open parenthesis.
                if (r_count != '0 && w_top.code != bip_pkg::OP_LPAR) begin
                    if (w_out_free) begin
                        w_cmd.pop   = 1'b1;
                        n_count     = r_count - CNT_W'(1);
                        n_out_valid = 1'b1;
                        n_kind      = bip_pkg::KD_TOKEN;
                        n_tok       = bip_pkg::code_char(w_top.code);
                        n_spos      = w_top.pos;
                        n_status    = bip_pkg::ST_OK;
                        n_last      = !(w_has_next && w_next.code != bip_pkg::OP_LPAR);
                    end
                end else begin
                    if (r_count != '0) begin
                        w_cmd.pop = 1'b1;
                        n_count   = r_count - CNT_W'(1);
                    end
                    n_paren = r_paren - CNT_W'(1);
                    n_state = S_IDLE;
                end
            end

            S_POP_END: begin
                // Drain the remaining operators ahead of the status.
                if (r_count != '0) begin
                    if (w_out_free) begin
                        w_cmd.pop   = 1'b1;
                        n_count     = r_count - CNT_W'(1);
                        n_out_valid = 1'b1;
                        n_kind      = bip_pkg::KD_TOKEN;
                        n_tok       = bip_pkg::code_char(w_top.code);
                        n_spos      = w_top.pos;
                        n_status    = bip_pkg::ST_OK;
                        n_last      = 1'b0;
                    end
                end else begin
                    n_state = S_STATUS;
                end
            end

            S_STATUS: begin
                // Report and return to the empty-expression state.
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = bip_pkg::KD_STAT;
                    n_tok       = 8'd0;
                    n_spos      = 8'd0;
                    n_status    = r_err;
                    n_last      = 1'b1;
                    n_count     = '0;
                    n_paren     = '0;
                    n_want      = 1'b1;
                    n_char_idx  = '0;
                    n_err       = bip_pkg::ST_OK;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_paren     <= '0;
            r_want      <= 1'b1;
            r_char_idx  <= '0;
            r_err       <= bip_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_paren     <= n_paren;
            r_want      <= n_want;
            r_char_idx  <= n_char_idx;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_func   <= n_func;
        r_char   <= n_char;
        r_tcode  <= n_tcode;
        r_tpos   <= n_tpos;
        r_kind   <= n_kind;
        r_tok    <= n_tok;
        r_spos   <= n_spos;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_token_char      = r_tok;
    assign o_source_position = r_spos;
    assign o_status          = r_status;
    assign o_last            = r_last;

endmodule

// File: hdl/bip_checker.sv
module bip_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_func,
    input logic [7:0] i_char_code,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_kind,
    input logic [7:0] o_token_char,
    input logic [7:0] o_source_position,
    input logic [2:0] o_status,
    input logic       o_last
);

    // A status transaction always closes the output of its input transaction.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == bip_pkg::KD_STAT |-> o_last)
        else $error("Status transaction without last flag.");

    // Token transactions carry no status code.
    a_token_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == bip_pkg::KD_TOKEN |-> o_status == bip_pkg::ST_OK)
        else $error("Token transaction with a nonzero status.");

    // A status code stays within the defined set and has empty token fields.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == bip_pkg::KD_STAT |->
        o_status <= bip_pkg::ST_TOOLONG && o_token_char == 8'd0 &&
        o_source_position == 8'd0)
        else $error("Malformed status transaction.");

    // An accepted input transaction is decoded before the next one is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Input accepted on two consecutive cycles.");

    // A stalled output transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) &&
        $stable(o_token_char) && $stable(o_source_position) &&
        $stable(o_status) && $stable(o_last))
        else $error("Output transaction changed while stalled.");

endmodule

bind boolean_infix_to_postfix_unit bip_checker u_bip_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int STK_DEPTH     = 32;
    localparam int MAX_CHARS     = 256;
    localparam int RANDOM_ITEMS  = 100;
    localparam int TAIL_ITEMS    = 50;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // One input transaction: an expression character or the end marker.
    typedef struct {
        logic       fn;
        logic [7:0] ch;
    } t_char_item;

    // One output transaction: a postfix token or the closing status.
    typedef struct {
        logic       kind;
        logic [7:0] tok;
        logic [7:0] pos;
        logic [2:0] stat;
        logic       last;
    } t_token;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_func      = bip_pkg::FN_CHAR;
    logic [7:0] i_char_code = 8'd0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_kind;
    logic [7:0] o_token_char;
    logic [7:0] o_source_position;
    logic [2:0] o_status;
    logic       o_last;

    boolean_infix_to_postfix_unit #(
        .STACK_DEPTH(STK_DEPTH),
        .MAX_LEN    (MAX_CHARS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_char_code      (i_char_code),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_token_char     (o_token_char),
        .o_source_position(o_source_position),
        .o_status         (o_status),
        .o_last           (o_last)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Converter state as tracked by the testbench.
    // ------------------------------------------------------------------
    logic [2:0] opr_stk [STK_DEPTH];
    logic [7:0] pos_stk [STK_DEPTH];
    int         stk_n        = 0;
    int         open_parens  = 0;
    int         chars_seen   = 0;
    bit         need_operand = 1'b1;
    logic [2:0] fault        = bip_pkg::ST_OK;

    t_token staged_tokens[$];
    t_token expected_tokens[$];
    int     error_count = 0;

    function automatic logic [7:0] op_symbol(input logic [2:0] code);
        case (code)
            bip_pkg::OP_IFF:  return bip_pkg::CH_IFF;
            bip_pkg::OP_IMP:  return bip_pkg::CH_IMP;
            bip_pkg::OP_OR:   return bip_pkg::CH_OR;
            bip_pkg::OP_XOR:  return bip_pkg::CH_XOR;
            bip_pkg::OP_AND:  return bip_pkg::CH_AND;
            bip_pkg::OP_NOT:  return bip_pkg::CH_NOT;
            default:          return bip_pkg::CH_LPAR;
        endcase
    endfunction

    // Binary operators only; anything else maps to the parenthesis code.
    function automatic logic [2:0] binary_code(input logic [7:0] c);
        case (c)
            bip_pkg::CH_IFF:  return bip_pkg::OP_IFF;
            bip_pkg::CH_IMP:  return bip_pkg::OP_IMP;
            bip_pkg::CH_OR:   return bip_pkg::OP_OR;
            bip_pkg::CH_XOR:  return bip_pkg::OP_XOR;
            bip_pkg::CH_AND:  return bip_pkg::OP_AND;
            default:          return bip_pkg::OP_LPAR;
        endcase
    endfunction

    function automatic bit is_operand(input logic [7:0] c);
        return (c >= bip_pkg::CH_LOW_A && c <= bip_pkg::CH_LOW_Z) ||
               c == bip_pkg::CH_ZERO || c == bip_pkg::CH_ONE;
    endfunction

    task automatic emit_token(input logic kind, input logic [7:0] tok,
                              input logic [7:0] pos, input logic [2:0] stat);
        t_token t;
        t.kind = kind;
        t.tok  = tok;
        t.pos  = pos;
        t.stat = stat;
        t.last = 1'b0;
        staged_tokens.push_back(t);
    endtask

    task automatic pop_operator();
        stk_n--;
        emit_token(bip_pkg::KD_TOKEN, op_symbol(opr_stk[stk_n]), pos_stk[stk_n],
                   bip_pkg::ST_OK);
    endtask

    // A push onto a full stack is an overflow.
    function automatic bit push_operator(input logic [2:0] code, input int pos);
        if (stk_n >= STK_DEPTH) begin
            fault = bip_pkg::ST_OVERFLOW;
            return 1'b0;
        end
        opr_stk[stk_n] = code;
        pos_stk[stk_n] = pos[7:0];
        stk_n++;
        return 1'b1;
    endfunction

    task automatic clear_state();
        stk_n        = 0;
        open_parens  = 0;
        chars_seen   = 0;
        need_operand = 1'b1;
        fault        = bip_pkg::ST_OK;
    endtask

    task automatic convert_char(input logic [7:0] c);
        int         pos;
        logic [2:0] code;
        logic [2:0] top;
        bit         ok;
        bit         stop;
        if (chars_seen >= MAX_CHARS) begin
            fault = bip_pkg::ST_TOOLONG;
        end else begin
            pos  = chars_seen;
            chars_seen++;
            code = binary_code(c);
            if (c == bip_pkg::CH_SPACE) begin
                // Skipped, but it still takes a position.
            end else if (is_operand(c)) begin
                if (!need_operand) begin
                    fault = bip_pkg::ST_MISPLACED;
                end else begin
                    need_operand = 1'b0;
                    emit_token(bip_pkg::KD_TOKEN, c, pos[7:0], bip_pkg::ST_OK);
                end
            end else if (c == bip_pkg::CH_LPAR) begin
                if (!need_operand) begin
                    fault = bip_pkg::ST_MISPLACED;
                end else begin
                    ok = push_operator(bip_pkg::OP_LPAR, pos);
                    if (ok) open_parens++;
                end
            end else if (c == bip_pkg::CH_RPAR) begin
                // An unmatched parenthesis wins over a misplaced one.
                if (open_parens == 0) begin
                    fault = bip_pkg::ST_PARENS;
                end else if (need_operand) begin
                    fault = bip_pkg::ST_MISPLACED;
                end else begin
                    while (stk_n > 0 && opr_stk[stk_n - 1] != bip_pkg::OP_LPAR)
                        pop_operator();
                    if (stk_n > 0) stk_n--;
                    open_parens--;
                end
            end else if (c == bip_pkg::CH_NOT) begin
                if (!need_operand) begin
                    fault = bip_pkg::ST_MISPLACED;
                end else begin
                    ok = push_operator(bip_pkg::OP_NOT, pos);
                end
            end else if (code == bip_pkg::OP_LPAR) begin
                fault = bip_pkg::ST_BADCHAR;
            end else if (need_operand) begin
                fault = bip_pkg::ST_MISPLACED;
            end else begin
                // Pop while the stacked operator binds at least as tightly;
                // implication is right associative and needs strictly tighter.
                stop = 1'b0;
                while (!stop && stk_n > 0) begin
                    top = opr_stk[stk_n - 1];
                    if (top == bip_pkg::OP_LPAR) begin
                        stop = 1'b1;
                    end else if ((code == bip_pkg::OP_IMP) ? (top <= code) : (top < code)) begin
                        stop = 1'b1;
                    end else begin
                        pop_operator();
                    end
                end
                need_operand = 1'b1;
                ok = push_operator(code, pos);
            end
        end
    endtask

    // Works out every output transaction caused by one input transaction.
    task automatic convert_item(input logic fn, input logic [7:0] c);
        logic [2:0] st;
        t_token     t;
        int         k;
        staged_tokens.delete();
        if (fn == bip_pkg::FN_CHAR) begin
            if (fault == bip_pkg::ST_OK) convert_char(c);
        end else begin
            st = fault;
            if (st == bip_pkg::ST_OK) begin
                if (need_operand) st = bip_pkg::ST_MISPLACED;
                else if (open_parens != 0) st = bip_pkg::ST_PARENS;
            end
            if (st == bip_pkg::ST_OK) begin
                while (stk_n > 0) pop_operator();
            end
            emit_token(bip_pkg::KD_STAT, 8'd0, 8'd0, st);
            clear_state();
        end
        for (k = 0; k < staged_tokens.size(); k++) begin
            t      = staged_tokens[k];
            t.last = (k == staged_tokens.size() - 1);
            expected_tokens.push_back(t);
        end
    endtask

    task automatic report_error(input string msg);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_result();
        t_token want;
        if (expected_tokens.size() == 0) begin
            report_error($sformatf("unexpected kind %0d char %02h pos %0d status %0d last %0d",
                                   o_kind, o_token_char, o_source_position, o_status, o_last));
        end else begin
            want = expected_tokens.pop_front();
            if (o_kind !== want.kind || o_token_char !== want.tok ||
                o_source_position !== want.pos || o_status !== want.stat ||
                o_last !== want.last) begin
                report_error($sformatf(
                    "got kind %0d char %02h pos %0d status %0d last %0d, want %0d %02h %0d %0d %0d",
                    o_kind, o_token_char, o_source_position, o_status, o_last,
                    want.kind, want.tok, want.pos, want.stat, want.last));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------
    logic [7:0] text_buf[$];
    t_char_item pending[$];
    int         queued_items = 0;

    function automatic logic [7:0] rand_operand();
        int r;
        r = $urandom_range(0, 27);
        if (r < 26) return 8'(bip_pkg::CH_LOW_A + r);
        if (r == 26) return bip_pkg::CH_ZERO;
        return bip_pkg::CH_ONE;
    endfunction

    function automatic logic [7:0] rand_binary();
        case ($urandom_range(0, 4))
            0:       return bip_pkg::CH_IFF;
            1:       return bip_pkg::CH_IMP;
            2:       return bip_pkg::CH_OR;
            3:       return bip_pkg::CH_XOR;
            default: return bip_pkg::CH_AND;
        endcase
    endfunction

    function automatic logic [7:0] rand_lang_char();
        case ($urandom_range(0, 7))
            0:       return bip_pkg::CH_SPACE;
            1:       return bip_pkg::CH_LPAR;
            2:       return bip_pkg::CH_RPAR;
            3:       return bip_pkg::CH_NOT;
            4, 5:    return rand_binary();
            default: return rand_operand();
        endcase
    endfunction

    task automatic put_char(input logic [7:0] c);
        if ($urandom_range(0, 9) == 0) text_buf.push_back(bip_pkg::CH_SPACE);
        text_buf.push_back(c);
    endtask

    // Appends the buffered text as character transactions plus the end marker.
    task automatic flush_expr();
        t_char_item it;
        foreach (text_buf[k]) begin
            it.fn = bip_pkg::FN_CHAR;
            it.ch = text_buf[k];
            pending.push_back(it);
        end
        it.fn = bip_pkg::FN_END;
        it.ch = 8'($urandom_range(0, 255));
        pending.push_back(it);
        queued_items += text_buf.size() + 1;
        text_buf.delete();
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
        flush_expr();
    endtask

    // Well-formed expression of roughly the given length, built left to right.
    task automatic build_formula(input int target_len);
        bit need;
        int depth;
        bit done;
        int r;
        need  = 1'b1;
        depth = 0;
        done  = 1'b0;
        while (!done) begin
            if (need) begin
                r = $urandom_range(0, 9);
                if (text_buf.size() < target_len && r < 2) begin
                    put_char(bip_pkg::CH_NOT);
                end else if (text_buf.size() < target_len && r < 4 && depth < 6) begin
                    put_char(bip_pkg::CH_LPAR);
                    depth++;
                end else begin
                    put_char(rand_operand());
                    need = 1'b0;
                end
            end else if (depth > 0 &&
                         ($urandom_range(0, 2) == 0 || text_buf.size() >= target_len)) begin
                put_char(bip_pkg::CH_RPAR);
                depth--;
            end else if (text_buf.size() >= target_len) begin
                done = 1'b1;
            end else begin
                put_char(rand_binary());
                need = 1'b1;
            end
        end
    endtask

    // Long runs of NOT or open parentheses fill the stack to and past its depth.
    task automatic build_deep(input bit parens, input int count);
        for (int k = 0; k < count; k++)
            text_buf.push_back(parens ? bip_pkg::CH_LPAR : bip_pkg::CH_NOT);
        text_buf.push_back(rand_operand());
        if (parens) begin
            for (int k = 0; k < count; k++) text_buf.push_back(bip_pkg::CH_RPAR);
        end
    endtask

    task automatic build_broken();
        int idx;
        build_formula($urandom_range(1, 10));
        idx = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 4))
            0: text_buf[idx] = 8'($urandom_range(0, 255));
            1: text_buf[idx] = rand_lang_char();
            2: if (text_buf.size() > 1) text_buf.delete(text_buf.size() - 1);
            3: text_buf.push_back($urandom_range(0, 1) ? bip_pkg::CH_RPAR : bip_pkg::CH_LPAR);
            default: text_buf.push_front(rand_lang_char());
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input driver: one transaction at a time from the pending queue.
    // ------------------------------------------------------------------
    t_char_item drv_item;
    int         gap_left  = 0;
    int         calm_left = 0;
    int         drv_pick;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending.size() > 0) begin
                drv_item = pending.pop_front();
                i_in_valid  <= 1'b1;
                i_func      <= drv_item.fn;
                i_char_code <= drv_item.ch;
                // Idle bursts and quiet stretches, none near the end.
                if (calm_left > 0) begin
                    calm_left--;
                end else if (pending.size() > TAIL_ITEMS) begin
                    drv_pick = $urandom_range(0, 19);
                    if (drv_pick == 0) calm_left = $urandom_range(20, 80);
                    else if (drv_pick < 5) gap_left = $urandom_range(1, 11);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks output transactions, then predicts from accepted input.
    // ------------------------------------------------------------------
    int hold_left     = 0;
    int rdy_calm_left = 0;
    int rdy_pick;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) check_result();
            if (i_in_valid && o_in_ready) convert_item(i_func, i_char_code);
        end
        // Receiver stalls in bursts.
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (rdy_calm_left > 0) begin
                rdy_calm_left--;
            end else if (pending.size() > TAIL_ITEMS) begin
                rdy_pick = $urandom_range(0, 15);
                if (rdy_pick == 0) rdy_calm_left = $urandom_range(30, 150);
                else if (rdy_pick < 3) hold_left = $urandom_range(1, 11);
            end
        end
    end

    // Watchdog.
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    int random_start;
    int shape;

    initial begin
        // Directed: empty expression, every operator with both associativities,
        // a bad character, an unmatched close and an open parenthesis at end.
        put_text("");
        put_text("-(a&z)#0|1>b>c=d");
        put_text("A");
        put_text(")");
        put_text("(a");

        // Full stack giving the most results, stack overflow, and over-length.
        build_deep(1'b0, STK_DEPTH);
        flush_expr();
        build_deep(1'b1, STK_DEPTH + 1);
        flush_expr();
        build_formula(MAX_CHARS + 6);
        flush_expr();

        // Random part: mostly well-formed, some broken, some noise.
        random_start = queued_items;
        while (queued_items - random_start < RANDOM_ITEMS) begin
            shape = $urandom_range(0, 99);
            if (shape < 68) begin
                build_formula($urandom_range(1, 12));
            end else if (shape < 84) begin
                build_broken();
            end else if (shape < 91) begin
                repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
            end else if (shape < 95) begin
                build_deep(1'($urandom_range(0, 1)),
                           $urandom_range(STK_DEPTH - 4, STK_DEPTH + 2));
            end else begin
                build_formula($urandom_range(20, 40));
            end
            flush_expr();
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Waits sample on the falling edge, after all clocked updates.
        do @(negedge i_clk); while (pending.size() != 0 || i_in_valid);
        while (expected_tokens.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
